// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/bsm_pkg.sv -----
// ---------------------------------------------------------------------------
// Bounding sphere merge package
// Shared widths, the pipeline stage and result records and the saturation helper.
// ---------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

   localparam int AXES     = 3;
   localparam int ROOT_W   = 34;
   localparam int WORK_W   = 69;
   localparam int DEN_W    = 35;
   localparam int MAG_W    = 33;

   // One item as it travels through the pipeline.  The work words hold the
   // squares, then the root remainder, then the products and the division
   // remainders, depending on the stage.
   typedef struct packed {
      logic                                valid;
      logic [AXES-1:0][31:0]               c1;
      logic [AXES-1:0]                     dneg;
      logic [AXES-1:0][MAG_W-1:0]          dmag;
      logic [30:0]                         r1;
      logic [30:0]                         r2;
      logic [AXES-1:0][WORK_W-1:0]         wk;
      logic [ROOT_W-1:0]                   root;
      logic [AXES-1:0][ROOT_W-1:0]         quo;
      logic [DEN_W-1:0]                    den;
      logic                                deg;
   } stage_type;

   // Merged sphere as it leaves the block.
   typedef struct packed {
      logic                  valid;
      logic [AXES-1:0][31:0] center;
      logic [30:0]           radius;
      logic                  deg;
   } result_type;

   // Clamp a 36-bit signed value to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      logic [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bsm_if.sv -----
// ---------------------------------------------------------------------------
// Bounding sphere merge channels
// Valid/ready channels for sphere pairs and for merged spheres.
// ---------------------------------------------------------------------------
`default_nettype none

interface bsm_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] first_center_x;
   logic [31:0] first_center_y;
   logic [31:0] first_center_z;
   logic [30:0] first_radius;
   logic [31:0] second_center_x;
   logic [31:0] second_center_y;
   logic [31:0] second_center_z;
   logic [30:0] second_radius;

   modport source (output valid, first_center_x, first_center_y, first_center_z,
                   first_radius, second_center_x, second_center_y, second_center_z,
                   second_radius, input ready);
   modport sink (input valid, first_center_x, first_center_y, first_center_z,
                 first_radius, second_center_x, second_center_y, second_center_z,
                 second_radius, output ready);
endinterface

interface bsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] merged_center_x;
   logic [31:0] merged_center_y;
   logic [31:0] merged_center_z;
   logic [30:0] merged_radius;
   logic        degenerate;

   modport source (output valid, merged_center_x, merged_center_y, merged_center_z,
                   merged_radius, degenerate, input ready);
   modport sink (input valid, merged_center_x, merged_center_y, merged_center_z,
                 merged_radius, degenerate, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bsm_root_step.sv -----
// ---------------------------------------------------------------------------
// Square root step
// Decides one bit of the floor square root and registers the item.
// ---------------------------------------------------------------------------
`default_nettype none

module bsm_root_step #(
   parameter int BIT = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire bsm_pkg::stage_type stage_in,
   output bsm_pkg::stage_type     stage_out
);

   bsm_pkg::stage_type stage_ff;
   bsm_pkg::stage_type next_in;
   logic [bsm_pkg::WORK_W-1:0] trial;

   // Growth of the square when this bit is set: 2^(b+1) r + 2^(2b).
   always_comb begin
      trial   = (bsm_pkg::WORK_W'(stage_in.root) << (BIT + 1))
              + (bsm_pkg::WORK_W'(1) << (2 * BIT));
      next_in = stage_in;
      if (stage_in.wk[0] >= trial) begin
         next_in.wk[0]     = stage_in.wk[0] - trial;
         next_in.root[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= next_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bsm_div_step.sv -----
// ---------------------------------------------------------------------------
// Division step
// Decides one quotient bit on all three axes and registers the item.
// ---------------------------------------------------------------------------
`default_nettype none

module bsm_div_step #(
   parameter int BIT = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire bsm_pkg::stage_type stage_in,
   output bsm_pkg::stage_type     stage_out
);

   bsm_pkg::stage_type stage_ff;
   bsm_pkg::stage_type next_in;
   logic [bsm_pkg::WORK_W-1:0] trial;

   // Restoring division: subtract the shifted divisor where it fits.
   always_comb begin
      trial   = bsm_pkg::WORK_W'(stage_in.den) << BIT;
      next_in = stage_in;
      for (int k = 0; k < bsm_pkg::AXES; k++) begin
         if (stage_in.wk[k] >= trial) begin
            next_in.wk[k]       = stage_in.wk[k] - trial;
            next_in.quo[k][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= next_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bounding_sphere_merge_top.sv -----
// ---------------------------------------------------------------------------
// Bounding sphere merge
// Unites two spheres in Q15.16 into one enclosing sphere.
// ---------------------------------------------------------------------------
// Usage:
// An item on req_chan carries two spheres (centre and radius each); one
// merged sphere leaves on rsp_chan for every item, in order.
// The stages are one for the centre difference, one for the squares, one for
// their sum, 34 for the bit-per-stage square root, two to form the scale and
// the products, 34 for the bit-per-stage division on all three axes, and the
// output register.
// Throughput is one item per cycle unless a waiting result stalls the pipeline.
// The whole pipeline moves on one enable; when rsp_chan.ready is low while
// a result waits, every stage holds and req_chan.ready drops, so nothing is
// lost or repeated.
// A synchronous reset empties the pipeline; no other state is kept.
// Coincident centres give the first centre, the larger radius and the
// degenerate flag.
// ---------------------------------------------------------------------------
`default_nettype none

module bounding_sphere_merge_top (
   input  wire logic clock,
   input  wire logic reset,
   bsm_req_if.sink   req_chan,
   bsm_rsp_if.source rsp_chan
);

   localparam int STEPS = bsm_pkg::ROOT_W;

   logic                  enable;
   bsm_pkg::stage_type    diff_ff, diff_in;
   bsm_pkg::stage_type    sq_ff, sq_in;
   bsm_pkg::stage_type    root_st [0:STEPS];
   bsm_pkg::stage_type    scale_ff, scale_in;
   bsm_pkg::stage_type    prod_in;
   bsm_pkg::result_type   out_ff, out_in;
   bsm_pkg::stage_type    sum_ff, sum_in;

   logic signed [32:0]    dv [bsm_pkg::AXES];
   logic [31:0]           c2 [bsm_pkg::AXES];
   logic signed [35:0]    nval;
   logic signed [35:0]    cv [bsm_pkg::AXES];
   logic [35:0]           rad_sum;

   // The pipeline advances unless a finished result is held up.
   assign enable         = !out_ff.valid || rsp_chan.ready;
   assign req_chan.ready = enable;

   // Centre differences and their magnitudes.
   always_comb begin
      diff_in       = '0;
      diff_in.valid = req_chan.valid;
      diff_in.c1[0] = req_chan.first_center_x;
      diff_in.c1[1] = req_chan.first_center_y;
      diff_in.c1[2] = req_chan.first_center_z;
      diff_in.r1    = req_chan.first_radius;
      diff_in.r2    = req_chan.second_radius;
      c2[0]         = req_chan.second_center_x;
      c2[1]         = req_chan.second_center_y;
      c2[2]         = req_chan.second_center_z;
      for (int k = 0; k < bsm_pkg::AXES; k++) begin
         dv[k] = $signed({c2[k][31], c2[k]}) - $signed({diff_in.c1[k][31], diff_in.c1[k]});
         diff_in.dneg[k] = dv[k][32];
         diff_in.dmag[k] = dv[k][32] ? 33'(-dv[k]) : 33'(dv[k]);
      end
   end

   // Squares of the difference magnitudes.
   always_comb begin
      sq_in = diff_ff;
      for (int k = 0; k < bsm_pkg::AXES; k++) begin
         sq_in.wk[k] = bsm_pkg::WORK_W'(diff_ff.dmag[k]) * bsm_pkg::WORK_W'(diff_ff.dmag[k]);
      end
   end

   // Sum of squares seeds the root remainder.
   always_comb begin
      sum_in       = sq_ff;
      sum_in.wk[0] = sq_ff.wk[0] + sq_ff.wk[1] + sq_ff.wk[2];
      sum_in.root  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff.valid <= 1'b0;
         sq_ff.valid   <= 1'b0;
         sum_ff.valid  <= 1'b0;
      end else if (enable) begin
         diff_ff <= diff_in;
         sq_ff   <= sq_in;
         sum_ff  <= sum_in;
      end
   end

   assign root_st[0] = sum_ff;

   // Floor square root, one bit per stage from the top.
   for (genvar j = 0; j < STEPS; j++) begin : g_root
      bsm_root_step #(.BIT(STEPS - 1 - j)) u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_in  (root_st[j]),
         .stage_out (root_st[j+1])
      );
   end

   // Scale numerator l + r2 - r1, its sign folded into each axis sign.
   always_comb begin
      scale_in      = root_st[STEPS];
      scale_in.deg  = (root_st[STEPS].root == '0);
      scale_in.den  = {root_st[STEPS].root, 1'b0};
      nval          = $signed(36'(root_st[STEPS].root)) + $signed(36'(root_st[STEPS].r2))
                    - $signed(36'(root_st[STEPS].r1));
      scale_in.root = nval[35] ? bsm_pkg::ROOT_W'(-nval) : bsm_pkg::ROOT_W'(nval);
      for (int k = 0; k < bsm_pkg::AXES; k++) begin
         scale_in.dneg[k] = root_st[STEPS].dneg[k] ^ nval[35];
      end
   end

   // Products of the difference magnitudes and the scale numerator.
   always_comb begin
      prod_in       = scale_ff;
      prod_in.quo   = '0;
      for (int k = 0; k < bsm_pkg::AXES; k++) begin
         prod_in.wk[k] = bsm_pkg::WORK_W'(scale_ff.dmag[k]) * bsm_pkg::WORK_W'(scale_ff.root);
      end
   end

   bsm_pkg::stage_type prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff.valid <= 1'b0;
         prod_ff.valid  <= 1'b0;
      end else if (enable) begin
         scale_ff <= scale_in;
         prod_ff  <= prod_in;
      end
   end

   bsm_pkg::stage_type dv_st [0:STEPS];
   assign dv_st[0] = prod_ff;

   // Quotient by twice the distance, one bit per stage from the top.
   for (genvar j = 0; j < STEPS; j++) begin : g_div
      bsm_div_step #(.BIT(STEPS - 1 - j)) u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_in  (dv_st[j]),
         .stage_out (dv_st[j+1])
      );
   end

   // Final centre offset, halved radius sum, saturation, degenerate case.
   always_comb begin
      out_in.valid = dv_st[STEPS].valid;
      out_in.deg   = dv_st[STEPS].deg;
      rad_sum      = 36'(dv_st[STEPS].den[bsm_pkg::DEN_W-1:1]) + 36'(dv_st[STEPS].r1)
                   + 36'(dv_st[STEPS].r2);
      for (int k = 0; k < bsm_pkg::AXES; k++) begin
         if (dv_st[STEPS].dneg[k]) begin
            cv[k] = $signed({{4{dv_st[STEPS].c1[k][31]}}, dv_st[STEPS].c1[k]})
                  - $signed({2'b00, dv_st[STEPS].quo[k]});
         end else begin
            cv[k] = $signed({{4{dv_st[STEPS].c1[k][31]}}, dv_st[STEPS].c1[k]})
                  + $signed({2'b00, dv_st[STEPS].quo[k]});
         end
         out_in.center[k] = dv_st[STEPS].deg ? dv_st[STEPS].c1[k] : bsm_pkg::sat32(cv[k]);
      end
      if (dv_st[STEPS].deg) begin
         out_in.radius = (dv_st[STEPS].r1 > dv_st[STEPS].r2) ? dv_st[STEPS].r1
                                                             : dv_st[STEPS].r2;
      end else if (rad_sum[35:32] != 4'b0000) begin
         out_in.radius = 31'h7FFF_FFFF;
      end else begin
         out_in.radius = rad_sum[31:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (enable) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid           = out_ff.valid;
   assign rsp_chan.merged_center_x = out_ff.center[0];
   assign rsp_chan.merged_center_y = out_ff.center[1];
   assign rsp_chan.merged_center_z = out_ff.center[2];
   assign rsp_chan.merged_radius   = out_ff.radius;
   assign rsp_chan.degenerate      = out_ff.deg;

endmodule

`default_nettype wire

// ----- hw/rtl/bsm_checker.sv -----
// ---------------------------------------------------------------------------
// Bounding sphere merge checker
// Port-level checks on the handshakes, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bsm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_cx,
   input wire logic [30:0] rsp_radius,
   input wire logic        rsp_deg
);

   // The pipeline is empty after reset.
   `ASSERT_CLK(a_empty_after_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // An empty pipeline takes items at once after reset.
   `ASSERT_CLK(a_ready_after_reset, clock, reset |=> req_ready, "not ready after reset")

   // A held-up result stalls the whole pipeline, input included.
   `ASSERT_CLK_RST(a_stall_blocks_input, clock, reset,
      rsp_valid && !rsp_ready |-> !req_ready, "input taken during output stall")

   // A waiting result keeps its value.
   `ASSERT_CLK_RST(a_result_held, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cx)
         && $stable(rsp_radius) && $stable(rsp_deg),
      "stalled result changed")

endmodule

bind bounding_sphere_merge_top bsm_checker u_bsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_cx     (rsp_chan.merged_center_x),
   .rsp_radius (rsp_chan.merged_radius),
   .rsp_deg    (rsp_chan.degenerate)
);

`default_nettype wire

// ----- bench/tb_bounding_sphere_merge_top.sv -----
// ---------------------------------------------------------------------------
// Sphere merge bench
// Drives sphere pairs into the merge pipeline with random gaps on both sides
// and a long output stall, and checks every merged sphere against a
// bit-accurate predictor built on wide integer arithmetic.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_bounding_sphere_merge_top;

   localparam int LATENCY   = 74;
   localparam int N_RANDOM  = 1130;
   localparam int N_DIRECT  = 12;
   localparam int MAX_S32   = 2147483647;

   typedef struct packed {
      logic [31:0] cx1, cy1, cz1;
      logic [30:0] r1;
      logic [31:0] cx2, cy2, cz2;
      logic [30:0] r2;
   } pair_type;

   typedef struct packed {
      logic [31:0] cx, cy, cz;
      logic [30:0] rad;
      logic        deg;
   } sphere_type;

   // One row of the directed table; has_exp marks rows with a typed-in answer.
   typedef struct packed {
      pair_type   pair;
      logic       has_exp;
      sphere_type exp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   n_errors = 0;
   int   n_merged = 0;
   int   n_degen  = 0;
   int   n_sat    = 0;
   bit   stall_done = 1'b0;
   bit   drive_done = 1'b0;

   sphere_type merged_q[$];
   row_type    table_rows[N_DIRECT];

   bsm_req_if req_chan ();
   bsm_rsp_if rsp_chan ();

   bounding_sphere_merge_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #6 clock = ~clock;

   initial begin
      #50ms;
      $display("tb_bounding_sphere_merge_top failed");
      $finish;
   end

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic [31:0] clamp32(input logic signed [71:0] v);
      if (v > 72'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -72'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Merged sphere of one pair: floor root of the squared distance, exact
   // centre offset truncated toward zero, halved radius sum.
   function automatic sphere_type merge_spheres(input pair_type p);
      sphere_type            s;
      logic signed [71:0]    c1 [3];
      logic signed [71:0]    dd [3];
      logic        [71:0]    sq;
      logic        [71:0]    root, trial, offs, num_mag;
      logic signed [71:0]    num;
      logic        [143:0]   prod;
      logic        [71:0]    rad;
      c1[0] = 72'(signed'(p.cx1));
      c1[1] = 72'(signed'(p.cy1));
      c1[2] = 72'(signed'(p.cz1));
      dd[0] = 72'(signed'(p.cx2)) - c1[0];
      dd[1] = 72'(signed'(p.cy2)) - c1[1];
      dd[2] = 72'(signed'(p.cz2)) - c1[2];
      sq = 0;
      for (int k = 0; k < 3; k++) sq += 72'(dd[k] * dd[k]);
      root = 0;
      for (int i = 33; i >= 0; i--) begin
         trial = root | (72'd1 << i);
         if (trial * trial <= sq) root = trial;
      end
      if (root == 0) begin
         s.cx = p.cx1; s.cy = p.cy1; s.cz = p.cz1;
         s.rad = (p.r1 > p.r2) ? p.r1 : p.r2;
         s.deg = 1'b1;
         return s;
      end
      num = signed'(root) + 72'(p.r2) - 72'(p.r1);
      num_mag = num < 0 ? -num : num;
      for (int k = 0; k < 3; k++) begin
         prod = 144'(dd[k] < 0 ? -dd[k] : dd[k]) * 144'(num_mag);
         offs = 72'(prod / 144'(root << 1));
         if ((dd[k] < 0) != (num < 0)) offs = -offs;
         case (k)
            0: s.cx = clamp32(c1[k] + signed'(offs));
            1: s.cy = clamp32(c1[k] + signed'(offs));
            default: s.cz = clamp32(c1[k] + signed'(offs));
         endcase
      end
      rad = (root + 72'(p.r1) + 72'(p.r2)) >> 1;
      s.rad = rad > 72'(MAX_S32) ? 31'h7FFF_FFFF : rad[30:0];
      s.deg = 1'b0;
      return s;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      logic [31:0] base;
      int mode;
      mode = $urandom_range(0, 9);
      p.cx1 = $urandom;
      p.cy1 = $urandom;
      p.cz1 = $urandom;
      p.r1  = 31'($urandom);
      p.cx2 = $urandom;
      p.cy2 = $urandom;
      p.cz2 = $urandom;
      p.r2  = 31'($urandom);
      // Half nearby spheres of sensible size, some coincident or nearly so, rest raw.
      if (mode < 5) begin
         base = $urandom;
         p.cx2 = p.cx1 + 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
         p.cy2 = p.cy1 + 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
         p.cz2 = p.cz1 + 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
         p.r1 = 31'(base[23:0]);
         p.r2 = 31'($urandom_range(0, 1 << 24));
      end else if (mode == 5) begin
         p.cx2 = p.cx1; p.cy2 = p.cy1; p.cz2 = p.cz1;
      end else if (mode == 6) begin
         p.cx2 = p.cx1 + 32'($urandom_range(0, 1));
         p.cy2 = p.cy1; p.cz2 = p.cz1 - 32'($urandom_range(0, 1));
      end
      return p;
   endfunction

   // Directed rows: extremes, coincident centres, saturation corners.
   initial begin
      pair_type p;
      sphere_type e;
      for (int i = 0; i < N_DIRECT; i++) begin
         table_rows[i].has_exp = 1'b0;
         table_rows[i].exp     = '0;
      end
      p = '0;
      e = '{cx: 0, cy: 0, cz: 0, rad: 0, deg: 1'b1};
      table_rows[0] = '{pair: p, has_exp: 1'b1, exp: e};
      p = '{cx1: 32'h8000_0000, cy1: 32'h7FFF_FFFF, cz1: 32'h8000_0000,
            r1: 31'h7FFF_FFFF, cx2: 32'h8000_0000, cy2: 32'h7FFF_FFFF,
            cz2: 32'h8000_0000, r2: 31'h0};
      e = '{cx: 32'h8000_0000, cy: 32'h7FFF_FFFF, cz: 32'h8000_0000,
            rad: 31'h7FFF_FFFF, deg: 1'b1};
      table_rows[1] = '{pair: p, has_exp: 1'b1, exp: e};
      p.r1 = 31'd5; p.r2 = 31'd9;
      e.rad = 31'd9;
      table_rows[2] = '{pair: p, has_exp: 1'b1, exp: e};
      table_rows[3].pair = '{cx1: 32'h8000_0000, cy1: 32'h8000_0000, cz1: 32'h8000_0000,
         r1: 31'h7FFF_FFFF, cx2: 32'h7FFF_FFFF, cy2: 32'h7FFF_FFFF,
         cz2: 32'h7FFF_FFFF, r2: 31'h7FFF_FFFF};
      table_rows[4].pair = '{cx1: 32'h7FFF_FFFF, cy1: 32'h7FFF_FFFF, cz1: 32'h7FFF_FFFF,
         r1: 31'h0, cx2: 32'h8000_0000, cy2: 32'h8000_0000,
         cz2: 32'h8000_0000, r2: 31'h7FFF_FFFF};
      table_rows[5].pair = '{cx1: 0, cy1: 0, cz1: 0, r1: 31'h7FFF_FFFF,
         cx2: 32'd1, cy2: 0, cz2: 0, r2: 0};
      table_rows[6].pair = '{cx1: 0, cy1: 0, cz1: 0, r1: 0,
         cx2: 32'hFFFF_FFFF, cy2: 0, cz2: 0, r2: 31'h7FFF_FFFF};
      table_rows[7].pair = '{cx1: 32'h0001_0000, cy1: 0, cz1: 0, r1: 31'h0001_0000,
         cx2: 32'hFFFF_0000, cy2: 0, cz2: 0, r2: 31'h0001_0000};
      table_rows[8].pair = '{cx1: 32'h0003_0000, cy1: 32'h0004_0000, cz1: 0,
         r1: 31'h0002_0000, cx2: 0, cy2: 0, cz2: 32'h0001_0000, r2: 31'h0010_0000};
      table_rows[9].pair = '{cx1: 32'h7FFF_FFFF, cy1: 32'h8000_0000, cz1: 0,
         r1: 31'h0, cx2: 32'h7FFF_FFFE, cy2: 32'h8000_0001, cz2: 32'h5555_5555,
         r2: 31'h7FFF_FFFF};
      table_rows[10].pair = '{cx1: 32'hAAAA_AAAA, cy1: 32'h5555_5555, cz1: 32'hFFFF_FFFF,
         r1: 31'h2AAA_AAAA, cx2: 32'h5555_5555, cy2: 32'hAAAA_AAAA, cz2: 32'h0,
         r2: 31'h5555_5555};
      table_rows[11].pair = '{cx1: 0, cy1: 0, cz1: 0, r1: 31'h7FFF_FFFF,
         cx2: 32'h8000_0000, cy2: 32'h8000_0000, cz2: 32'h8000_0000, r2: 0};
   end

   // Sender: directed table, then random pairs, with random gaps.
   initial begin
      pair_type p;
      int    n;
      req_chan.valid <= 1'b0;
      {req_chan.first_center_x, req_chan.first_center_y, req_chan.first_center_z,
       req_chan.first_radius, req_chan.second_center_x, req_chan.second_center_y,
       req_chan.second_center_z, req_chan.second_radius} <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      n = 0;
      while (n < N_DIRECT + N_RANDOM) begin
         @(posedge clock);
         if (req_chan.valid && req_chan.ready) n++;
         if (req_chan.valid && !req_chan.ready) continue;
         if (n >= N_DIRECT + N_RANDOM) begin
            req_chan.valid <= 1'b0;
         end else if ((n > 300 && n < 500) || $urandom_range(0, 99) >= 35) begin
            p = n < N_DIRECT ? table_rows[n].pair : random_pair();
            req_chan.valid           <= 1'b1;
            req_chan.first_center_x  <= p.cx1;
            req_chan.first_center_y  <= p.cy1;
            req_chan.first_center_z  <= p.cz1;
            req_chan.first_radius    <= p.r1;
            req_chan.second_center_x <= p.cx2;
            req_chan.second_center_y <= p.cy2;
            req_chan.second_center_z <= p.cz2;
            req_chan.second_radius   <= p.r2;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
      drive_done = 1'b1;
   end

   // Record the expected merge for every accepted pair.
   always @(posedge clock) begin
      pair_type   p;
      sphere_type e;
      int         idx;
      if (!reset && req_chan.valid && req_chan.ready) begin
         p = '{req_chan.first_center_x, req_chan.first_center_y, req_chan.first_center_z,
               req_chan.first_radius, req_chan.second_center_x, req_chan.second_center_y,
               req_chan.second_center_z, req_chan.second_radius};
         e = merge_spheres(p);
         idx = n_merged + merged_q.size();
         if (idx < N_DIRECT && table_rows[idx].has_exp && e != table_rows[idx].exp) begin
            $display("%0t: table row %0d disagrees with predictor", $time, idx);
            n_errors++;
         end
         if (e.deg) n_degen++;
         if (!e.deg && (e.rad == 31'h7FFF_FFFF || e.cx == 32'h7FFF_FFFF
             || e.cx == 32'h8000_0000)) n_sat++;
         merged_q.push_back(e);
      end
   end

   // Receiver: random stalls, plus one long hold-off early in the run.
   initial begin
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      repeat (40) @(posedge clock);
      rsp_chan.ready <= 1'b0;
      repeat (200) @(posedge clock);
      stall_done = 1'b1;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= (n_merged > 400 && n_merged < 600) ||
                           ($urandom_range(0, 99) >= 35);
      end
   end

   // Compare each merged sphere with the oldest expectation.
   always @(posedge clock) begin
      sphere_type got, e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.merged_center_x, rsp_chan.merged_center_y,
                 rsp_chan.merged_center_z, rsp_chan.merged_radius, rsp_chan.degenerate};
         if (merged_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            n_errors++;
         end else begin
            e = merged_q.pop_front();
            if (got.cx !== e.cx)
               $display("%0t: centre x expected %h actual %h", $time, e.cx, got.cx);
            if (got.cy !== e.cy)
               $display("%0t: centre y expected %h actual %h", $time, e.cy, got.cy);
            if (got.cz !== e.cz)
               $display("%0t: centre z expected %h actual %h", $time, e.cz, got.cz);
            if (got.rad !== e.rad)
               $display("%0t: radius expected %h actual %h", $time, e.rad, got.rad);
            if (got.deg !== e.deg)
               $display("%0t: degenerate expected %b actual %b", $time, e.deg, got.deg);
            if (got !== e) n_errors++;
         end
         n_merged++;
      end
   end

   // Drain, settle, report.
   initial begin
      wait (drive_done && stall_done);
      wait (merged_q.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      $display("Merged %0d sphere pairs: %0d coincident, %0d near saturation.",
               n_merged, n_degen, n_sat);
      if (n_errors == 0 && merged_q.size() == 0) begin
         $display("tb_bounding_sphere_merge_top passed");
      end else begin
         $display("tb_bounding_sphere_merge_top failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
